// ----- rtl/mi3d_pkg.sv -----
// shared types and constants for the minimum-image wrap block
// no dependencies; compiled first
`default_nettype none

package mi3d_pkg;

  localparam int COORD_W = 32;
  localparam int CFG_W   = 31;
  localparam int PROD_W  = 63;
  localparam int RED_W   = 33;
  localparam int ABS_W   = 32;
  localparam int SUM_W   = 34;
  localparam int LANES   = 3;
  localparam int STAGES  = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [CFG_W-1:0]         CELL_RESET   = CFG_W'(65536);
  localparam logic [COORD_W-1:0]       FRAC_HALF    = 32'h8000_0000;
  localparam logic signed [RED_W-1:0]  RED_HALF     = 33'sh0_8000_0000;
  localparam logic [SUM_W-1:0]         THREE_QUART  = 34'h0_C000_0000;
  localparam logic signed [63:0]       ROUND_BIAS   = 64'sh0000_0000_8000_0000;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_CUBIC,
    MODE_OCTA,
    MODE_INVALID
  } mode_e;

  typedef enum logic [1:0] {
    REG_MODE,
    REG_CELL,
    REG_INV_CELL
  } reg_idx_e;

  typedef struct packed {
    mode_e             mode;
    logic [CFG_W-1:0]  cell_size;
    logic [CFG_W-1:0]  inv_size;
  } cfg_t;

  typedef struct packed {
    logic en;
    logic fix;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/mi3d_if.sv -----
// request channels: displacement vector in, wrapped vector out
// depends on mi3d_pkg
`default_nettype none

interface mi3d_coord_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mi3d_pkg::COORD_W-1:0]   coord_x;
  logic signed [mi3d_pkg::COORD_W-1:0]   coord_y;
  logic signed [mi3d_pkg::COORD_W-1:0]   coord_z;

  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface mi3d_wrap_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mi3d_pkg::COORD_W-1:0]   wrapped_x;
  logic signed [mi3d_pkg::COORD_W-1:0]   wrapped_y;
  logic signed [mi3d_pkg::COORD_W-1:0]   wrapped_z;
  logic                                  mode_error;

  modport source (output valid, wrapped_x, wrapped_y, wrapped_z, mode_error, input ready);
  modport sink   (input valid, wrapped_x, wrapped_y, wrapped_z, mode_error, output ready);
endinterface

`default_nettype wire

// ----- rtl/mi3d_cfg.sv -----
// apb-style register file: cell mode, cell size, inverse cell size
// depends on mi3d_pkg
`default_nettype none

module mi3d_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mi3d_pkg::ADDR_W-1:0]   paddr,
  input  logic [mi3d_pkg::DATA_W-1:0]   pwdata,
  output logic [mi3d_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mi3d_pkg::cfg_t                cfg_o
);
  import mi3d_pkg::*;

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_MODE:     cfg_d.mode      = mode_e'(pwdata[1:0]);
        REG_CELL:     cfg_d.cell_size = pwdata[CFG_W-1:0];
        REG_INV_CELL: cfg_d.inv_size  = pwdata[CFG_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:     prdata = {{(DATA_W-2){1'b0}}, cfg_q.mode};
      REG_CELL:     prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.cell_size};
      REG_INV_CELL: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_q.inv_size};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode      <= MODE_NONE;
      cfg_q.cell_size <= CELL_RESET;
      cfg_q.inv_size  <= CELL_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/mi3d_lane.sv -----
// one component lane: scale, reduce to nearest image, octahedral fix, scale back
// depends on mi3d_pkg; four register stages sharing one enable
`default_nettype none

module mi3d_lane (
  input  logic                                 clk_i,
  input  mi3d_pkg::lane_ctrl_t                 ctrl_i,
  input  logic signed [mi3d_pkg::COORD_W-1:0]  coord_i,
  input  logic [mi3d_pkg::CFG_W-1:0]           inv_size_i,
  input  logic [mi3d_pkg::CFG_W-1:0]           cell_size_i,
  output logic [mi3d_pkg::ABS_W-1:0]           abs_r_o,
  output logic signed [mi3d_pkg::COORD_W-1:0]  scaled_o
);
  import mi3d_pkg::*;

  logic signed [63:0]          prod_s;
  logic signed [PROD_W-1:0]    s_q;
  logic [COORD_W-1:0]          frac;
  logic [PROD_W-COORD_W-1:0]   ipart;
  logic                        half_up;
  logic                        neg_r;
  logic signed [RED_W-1:0]     r_d, r_q, r_neg;
  logic [ABS_W-1:0]            abs_d, abs_q;
  logic                        pos_r;
  logic signed [RED_W-1:0]     c_d, c_q;
  logic signed [63:0]          p_d, p_q, rnd;

  // stage 1: scale by the inverse cell size
  assign prod_s = coord_i * $signed({1'b0, inv_size_i});

  // stage 2: reduce to [-0.5, 0.5]
  assign frac    = s_q[COORD_W-1:0];
  assign ipart   = s_q[PROD_W-1:COORD_W];
  // an exact half stays positive for integer part 0 or at most -2
  assign half_up = (ipart == '0) || (ipart[PROD_W-COORD_W-1] && !(&ipart));
  assign neg_r   = (frac[COORD_W-1] && |frac[COORD_W-2:0]) ||
                   ((frac == FRAC_HALF) && !half_up);
  assign r_d     = {neg_r, frac};
  assign r_neg   = -r_d;
  assign abs_d   = neg_r ? r_neg[ABS_W-1:0] : frac;

  // stage 3: half-cell shift towards the origin
  assign pos_r = !r_q[RED_W-1] && |r_q[RED_W-2:0];
  always_comb begin
    c_d = r_q;
    if (ctrl_i.fix) begin
      c_d = pos_r ? (r_q - RED_HALF) : (r_q + RED_HALF);
    end
  end

  // stage 4: scale back by the cell size
  assign p_d = c_q * $signed({1'b0, cell_size_i});

  // round half up to q16.16
  assign rnd      = p_q + ROUND_BIAS;
  assign scaled_o = rnd[63:COORD_W];
  assign abs_r_o  = abs_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      s_q   <= prod_s[PROD_W-1:0];
      r_q   <= r_d;
      abs_q <= abs_d;
      c_q   <= c_d;
      p_q   <= p_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mi3d_merge.sv -----
// merge of the three lanes: sum of reduced magnitudes against three quarters
// depends on mi3d_pkg
`default_nettype none

module mi3d_merge (
  input  mi3d_pkg::mode_e             mode_i,
  input  logic [mi3d_pkg::ABS_W-1:0]  abs_x_i,
  input  logic [mi3d_pkg::ABS_W-1:0]  abs_y_i,
  input  logic [mi3d_pkg::ABS_W-1:0]  abs_z_i,
  output logic                        fix_o
);
  import mi3d_pkg::*;

  logic [SUM_W-1:0] sum;

  assign sum   = SUM_W'(abs_x_i) + SUM_W'(abs_y_i) + SUM_W'(abs_z_i);
  assign fix_o = (mode_i == MODE_OCTA) && (sum > THREE_QUART);

endmodule

`default_nettype wire

// ----- rtl/minimum_image_wrap_3d.sv -----
// top level of the minimum-image wrap: registers, three lanes, merge, output register
// depends on mi3d_pkg, mi3d_if, mi3d_cfg, mi3d_lane, mi3d_merge
//
//   port      | dir | handshake       | payload
//   coord_i   | in  | valid / ready   | coord_x, coord_y, coord_z
//   wrap_o    | out | valid / ready   | wrapped_x, wrapped_y, wrapped_z, mode_error
//   apb       | in  | psel / penable  | paddr, pwdata, prdata
//
// one vector per cycle while the output is not stalled; four lane stages plus the output register
// the two multipliers per lane (scale and scale back) set the stage split
// reset clears valid bits and loads the register reset values
// a stalled output holds the whole pipeline; bubbles move with it and are not closed up
`default_nettype none

module minimum_image_wrap_3d (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mi3d_coord_if.sink                    coord_i,
  mi3d_wrap_if.source                   wrap_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mi3d_pkg::ADDR_W-1:0]   paddr,
  input  logic [mi3d_pkg::DATA_W-1:0]   pwdata,
  output logic [mi3d_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import mi3d_pkg::*;

  cfg_t                       cfg;
  logic                       en;
  logic                       in_acc;
  logic                       fix;
  logic [STAGES-1:0]          vld_q;
  logic                       out_vld_q;
  mode_e                      mode_q  [STAGES];
  logic signed [COORD_W-1:0]  coord_q [STAGES][LANES];
  logic signed [COORD_W-1:0]  coord_in [LANES];
  logic [ABS_W-1:0]           abs_r   [LANES];
  logic signed [COORD_W-1:0]  scaled  [LANES];
  logic signed [COORD_W-1:0]  res_q   [LANES];
  logic                       err_q;
  lane_ctrl_t                 lane_ctrl;
  logic                       wrap_mode;

  mi3d_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign en            = !out_vld_q || wrap_o.ready;
  assign coord_i.ready = en;
  assign in_acc        = coord_i.valid && en;

  assign coord_in[0] = coord_i.coord_x;
  assign coord_in[1] = coord_i.coord_y;
  assign coord_in[2] = coord_i.coord_z;

  assign lane_ctrl.en  = en;
  assign lane_ctrl.fix = fix;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    mi3d_lane u_lane (
      .clk_i       (clk_i),
      .ctrl_i      (lane_ctrl),
      .coord_i     (coord_in[l]),
      .inv_size_i  (cfg.inv_size),
      .cell_size_i (cfg.cell_size),
      .abs_r_o     (abs_r[l]),
      .scaled_o    (scaled[l])
    );
  end

  mi3d_merge u_merge (
    .mode_i  (mode_q[1]),
    .abs_x_i (abs_r[0]),
    .abs_y_i (abs_r[1]),
    .abs_z_i (abs_r[2]),
    .fix_o   (fix)
  );

  assign wrap_mode = (mode_q[STAGES-1] == MODE_CUBIC) || (mode_q[STAGES-1] == MODE_OCTA);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[STAGES-2:0], in_acc};
      out_vld_q <= vld_q[STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_q[0] <= cfg.mode;
      for (int l = 0; l < LANES; l++) begin
        coord_q[0][l] <= coord_in[l];
      end
      for (int k = 1; k < STAGES; k++) begin
        mode_q[k] <= mode_q[k-1];
        for (int l = 0; l < LANES; l++) begin
          coord_q[k][l] <= coord_q[k-1][l];
        end
      end
      for (int l = 0; l < LANES; l++) begin
        res_q[l] <= wrap_mode ? scaled[l] : coord_q[STAGES-1][l];
      end
      err_q <= (mode_q[STAGES-1] == MODE_INVALID);
    end
  end

  assign wrap_o.valid      = out_vld_q;
  assign wrap_o.wrapped_x  = res_q[0];
  assign wrap_o.wrapped_y  = res_q[1];
  assign wrap_o.wrapped_z  = res_q[2];
  assign wrap_o.mode_error = err_q;

endmodule

`default_nettype wire

// ----- rtl/mi3d_checker.sv -----
// port-level checks on the minimum-image wrap, bound to the top level
// depends on mi3d_pkg and minimum_image_wrap_3d
`default_nettype none

module mi3d_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mi3d_pkg::COORD_W-1:0]  out_x,
  input logic                          out_err,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [mi3d_pkg::ADDR_W-1:0]   paddr,
  input logic [mi3d_pkg::DATA_W-1:0]   pwdata,
  input logic [mi3d_pkg::DATA_W-1:0]   prdata,
  input logic                          pready
);
  import mi3d_pkg::*;

  logic mode_wr;
  logic mode_rd;

  assign mode_wr = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_MODE);
  assign mode_rd = psel && !pwrite && (paddr[ADDR_W-1:2] == REG_MODE);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_err))
    else $error("stalled result changed");

  // an empty output register never blocks the input
  a_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a taken result frees the input side
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready |-> in_ready)
    else $error("input stalled while result taken");

  // mode register reads back what was written
  a_mode_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_wr |=> (!mode_rd || (prdata[1:0] == $past(pwdata[1:0]))))
    else $error("mode readback mismatch");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low");

endmodule

bind minimum_image_wrap_3d mi3d_checker u_mi3d_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (coord_i.ready),
  .out_valid (wrap_o.valid),
  .out_ready (wrap_o.ready),
  .out_x     (wrap_o.wrapped_x),
  .out_err   (wrap_o.mode_error),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

`default_nettype wire

// ----- dv/minimum_image_wrap_3d_tb.sv -----
`timescale 1ns / 100ps
// testbench for minimum_image_wrap_3d: directed and random displacement vectors under
// every cell mode, results checked against an in-bench fixed-point wrap predictor
// needs mi3d_pkg, mi3d_if and the rtl of the block

module minimum_image_wrap_3d_tb;
  import mi3d_pkg::*;

  localparam longint HALF_Q32          = 64'sd2147483648;
  localparam longint ONE_Q32           = 64'sd4294967296;
  localparam longint THREE_QUARTER_Q32 = 64'sd3221225472;
  localparam longint Q16_MAX           = 64'sd2147483647;
  localparam longint Q16_MIN           = -64'sd2147483648;
  localparam int     CYCLE_LIMIT       = 300000;
  localparam int     DRAIN_CYCLES      = 12;
  localparam int     RANDOM_PHASES     = 12;
  localparam int     PHASE_VECTORS     = 35;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } coord_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        err;
  } wrap_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mi3d_coord_if coord_if ();
  mi3d_wrap_if  wrap_if ();

  minimum_image_wrap_3d dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coord_i (coord_if),
    .wrap_o  (wrap_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mode_e            cur_mode;
  logic [CFG_W-1:0] cur_cell;
  logic [CFG_W-1:0] cur_inv;
  wrap_t            pending_wraps [$];
  int unsigned      n_sent = 0;
  int unsigned      n_checked = 0;
  int unsigned      n_writes = 0;
  int unsigned      n_fail = 0;
  int unsigned      cycles = 0;
  int unsigned      tx_gap_max = 6;
  int unsigned      rx_wait_max = 6;
  int unsigned      rx_hold = 0;
  int unsigned      rx_wait = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic wrap_t wrap_vector(coord_t v);
    longint c [3];
    longint r [3];
    longint s;
    longint n;
    longint p;
    longint q;
    longint sum;
    int     i;
    wrap_t  w;
    c[0] = longint'($signed(v.x));
    c[1] = longint'($signed(v.y));
    c[2] = longint'($signed(v.z));
    w.err = (cur_mode == MODE_INVALID);
    if (cur_mode == MODE_CUBIC || cur_mode == MODE_OCTA) begin
      sum = 0;
      for (i = 0; i < 3; i++) begin
        s = c[i] * longint'(cur_inv);
        n = 0;
        if (s > HALF_Q32) n = (s + HALF_Q32) / ONE_Q32;
        else if (s < -HALF_Q32) n = -((-s + HALF_Q32) / ONE_Q32);
        r[i] = s - n * ONE_Q32;
        sum += (r[i] > 0) ? r[i] : -r[i];
      end
      // octahedral corner cut
      if (cur_mode == MODE_OCTA && sum > THREE_QUARTER_Q32) begin
        for (i = 0; i < 3; i++) r[i] += (r[i] > 0) ? -HALF_Q32 : HALF_Q32;
      end
      for (i = 0; i < 3; i++) begin
        p = r[i] * longint'(cur_cell);
        q = (p + HALF_Q32) >>> 32;
        if (q > Q16_MAX) q = Q16_MAX;
        if (q < Q16_MIN) q = Q16_MIN;
        c[i] = q;
      end
    end
    w.x = c[0][31:0];
    w.y = c[1][31:0];
    w.z = c[2][31:0];
    return w;
  endfunction

  function automatic logic [31:0] pick_component();
    longint t;
    int     k;
    case ($urandom_range(3, 0))
      0: return $urandom();
      1: return $urandom_range(32'h0003_ffff, 0) - 32'h0002_0000;
      2: begin
        // around a multiple of half a cell
        k = int'($urandom_range(16, 0)) - 8;
        t = k * longint'(cur_cell) / 2 + (longint'($urandom_range(64, 0)) - 32);
        if (t > Q16_MAX) t = Q16_MAX;
        if (t < Q16_MIN) t = Q16_MIN;
        return t[31:0];
      end
      default: begin
        case ($urandom_range(3, 0))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %h, got %h", name, want, got);
      n_fail++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin : check_wraps
    wrap_t want;
    if (rst_ni && wrap_if.valid && wrap_if.ready) begin
      if (pending_wraps.size() == 0) begin
        $error("unexpected result: x %h y %h z %h err %b", wrap_if.wrapped_x,
               wrap_if.wrapped_y, wrap_if.wrapped_z, wrap_if.mode_error);
        n_fail++;
      end else begin
        want = pending_wraps.pop_front();
        check_field("wrapped_x", want.x, wrap_if.wrapped_x);
        check_field("wrapped_y", want.y, wrap_if.wrapped_y);
        check_field("wrapped_z", want.z, wrap_if.wrapped_z);
        check_field("mode_error", {31'b0, want.err}, {31'b0, wrap_if.mode_error});
        n_checked++;
      end
      rx_wait = $urandom_range(rx_wait_max, 0);
    end
  end

  // receiver: long hold-off first, then the per-request stall
  initial begin
    wrap_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        wrap_if.ready = 1'b0;
        rx_hold--;
      end else if (rx_wait > 0) begin
        wrap_if.ready = 1'b0;
        rx_wait--;
      end else begin
        wrap_if.ready = 1'b1;
      end
    end
  end

  task automatic send_vector(input coord_t v);
    int unsigned gap;
    gap = $urandom_range(tx_gap_max, 0);
    repeat (gap) begin
      @(negedge clk_i);
      coord_if.valid = 1'b0;
    end
    @(negedge clk_i);
    coord_if.valid   = 1'b1;
    coord_if.coord_x = v.x;
    coord_if.coord_y = v.y;
    coord_if.coord_z = v.z;
    @(posedge clk_i);
    while (!coord_if.ready) @(posedge clk_i);
    pending_wraps.push_back(wrap_vector(v));
    n_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    coord_if.valid = 1'b0;
    while (pending_wraps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] index, input logic [31:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({index, 2'b00});
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (index)
      REG_MODE:     cur_mode = mode_e'(data[1:0]);
      REG_CELL:     cur_cell = data[CFG_W-1:0];
      REG_INV_CELL: cur_inv  = data[CFG_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_cell(input mode_e mode, input logic [31:0] cell_len,
                          input logic [31:0] inv);
    apb_write(REG_MODE, {30'b0, mode});
    apb_write(REG_CELL, cell_len);
    apb_write(REG_INV_CELL, inv);
  endtask

  task automatic test_no_wrap();
    send_vector('{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000});
    send_vector('{32'hffff_ffff, 32'h0000_0001, 32'h5555_5555});
    wait_drained();
  endtask

  task automatic test_invalid_mode();
    apb_write(REG_MODE, {30'b0, MODE_INVALID});
    send_vector('{32'haaaa_aaaa, 32'h8000_0000, 32'h7fff_ffff});
    send_vector('{32'h0001_0000, 32'hffff_0000, 32'h0000_0000});
    wait_drained();
  endtask

  task automatic test_cubic_halves();
    set_cell(MODE_CUBIC, 32'h0001_0000, 32'h0001_0000);
    send_vector('{32'h0000_8000, 32'hffff_8000, 32'h0000_8001});
    send_vector('{32'hffff_7fff, 32'h0001_8000, 32'h7fff_ffff});
    send_vector('{32'h8000_0000, 32'h0000_0000, 32'hffff_ffff});
    wait_drained();
  endtask

  task automatic test_octahedron();
    apb_write(REG_MODE, {30'b0, MODE_OCTA});
    send_vector('{32'h0000_6666, 32'h0000_6666, 32'h0000_6666});
    send_vector('{32'h0000_4000, 32'h0000_4000, 32'h0000_4000});
    send_vector('{32'h0000_8000, 32'hffff_8000, 32'h0000_0000});
    send_vector('{32'h3000_0000, 32'hc000_0001, 32'h1234_5678});
    wait_drained();
  endtask

  task automatic test_zero_cell();
    set_cell(MODE_CUBIC, 32'h0000_0000, 32'h0001_0000);
    send_vector('{32'h0001_2345, 32'h8000_0000, 32'h7fff_ffff});
    wait_drained();
    set_cell(MODE_CUBIC, 32'h0001_0000, 32'h0000_0000);
    send_vector('{32'h0001_2345, 32'hfffe_0000, 32'h7fff_ffff});
    wait_drained();
    // write to an unmapped register must leave the cell alone
    apb_write(2'd3, 32'hffff_ffff);
    send_vector('{32'h0002_8000, 32'hfffd_8000, 32'h0000_c000});
    wait_drained();
  endtask

  task automatic test_backpressure();
    coord_t v;
    set_cell(MODE_OCTA, 32'h0004_0000, 32'h0000_4000);
    tx_gap_max = 0;
    @(posedge clk_i);
    rx_hold = 80;
    repeat (30) begin
      v.x = pick_component();
      v.y = pick_component();
      v.z = pick_component();
      send_vector(v);
    end
    wait_drained();
    tx_gap_max = 6;
  endtask

  task automatic test_random_settings();
    coord_t      v;
    logic [31:0] cell_len;
    logic [31:0] inv;
    int unsigned sh;
    int unsigned pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = (phase % 5 == 2) ? 3 : $urandom_range(4, 0);
      case (pick)
        0: begin
          cell_len = 32'h0001_0000;
          inv      = 32'h0001_0000;
        end
        1: begin
          sh       = $urandom_range(22, 12);
          cell_len = 32'd1 << sh;
          inv      = 32'd1 << (32 - sh);
        end
        2: begin
          cell_len = $urandom_range(32'h0040_0000, 32'h0000_1000);
          inv      = 32'((ONE_Q32 + longint'(cell_len) / 2) / longint'(cell_len));
        end
        3: begin
          case ($urandom_range(2, 0))
            0: begin cell_len = 32'h7fff_ffff; inv = 32'h0000_0001; end
            1: begin cell_len = 32'h0000_0001; inv = 32'h7fff_ffff; end
            default: begin cell_len = 32'h7fff_ffff; inv = 32'h7fff_ffff; end
          endcase
        end
        default: begin
          cell_len = $urandom();
          inv      = $urandom();
        end
      endcase
      if ($urandom_range(1, 0) == 1) cell_len[31] = 1'b1;
      if ($urandom_range(1, 0) == 1) inv[31] = 1'b1;
      apb_write(REG_MODE, ($urandom() & 32'hffff_fffc) | (phase % 4));
      apb_write(REG_CELL, cell_len);
      apb_write(REG_INV_CELL, inv);
      tx_gap_max  = ($urandom_range(3, 0) == 0) ? 0 : 6;
      rx_wait_max = ($urandom_range(3, 0) == 0) ? 0 : 6;
      repeat (PHASE_VECTORS) begin
        v.x = pick_component();
        v.y = pick_component();
        v.z = pick_component();
        send_vector(v);
      end
      wait_drained();
    end
    tx_gap_max  = 6;
    rx_wait_max = 6;
  endtask

  initial begin
    coord_if.valid   = 1'b0;
    coord_if.coord_x = '0;
    coord_if.coord_y = '0;
    coord_if.coord_z = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    cur_mode = MODE_NONE;
    cur_cell = CELL_RESET;
    cur_inv  = CELL_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_no_wrap();
    test_invalid_mode();
    test_cubic_halves();
    test_octahedron();
    test_zero_cell();
    test_backpressure();
    test_random_settings();

    $display("%0d vectors sent and %0d results checked across all four cell modes",
             n_sent, n_checked);
    $display("%0d register writes incl. zero, extreme and unmapped settings, %0d mismatches",
             n_writes, n_fail);
    if (n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mi3d_pkg.sv
rtl/mi3d_if.sv
rtl/mi3d_cfg.sv
rtl/mi3d_lane.sv
rtl/mi3d_merge.sv
rtl/minimum_image_wrap_3d.sv
rtl/mi3d_checker.sv
dv/minimum_image_wrap_3d_tb.sv
